[sv/cfd_pkg.sv]
package cfd_pkg;

  localparam int unsigned MIN_FRAME_BYTES = 3;
  localparam logic [15:0] MIN_BYTES_BEFORE_DELIM = 16'(MIN_FRAME_BYTES - 1);
  localparam logic [15:0] BYTE_COUNT_MAX = 16'hFFFF;

  typedef struct packed {
    logic        at_frame_start;
    logic [7:0]  distance_left;
    logic [15:0] frame_bytes;
  } cfd_state_t;

  typedef struct packed {
    logic        valid;
    logic [7:0]  out_byte;
    logic        frame_end;
    logic        status;
    logic [15:0] byte_count;
  } cfd_result_t;

  localparam cfd_state_t STATE_RESET = '{
    at_frame_start: 1'b1,
    distance_left:  8'd0,
    frame_bytes:    16'd0
  };

endpackage

[sv/cfd_core.sv]
module cfd_core (
  input  logic [7:0]          in_byte,
  input  logic [7:0]          delimiter_byte,
  input  cfd_pkg::cfd_state_t st,
  output cfd_pkg::cfd_state_t st_next,
  output cfd_pkg::cfd_result_t res
);
  import cfd_pkg::*;

  logic        is_delim;
  logic        dist_zero;
  logic        frame_ok;
  logic [7:0]  dist_base;
  logic [15:0] bytes_inc;

  assign is_delim  = (in_byte == delimiter_byte);
  assign dist_zero = (st.distance_left == 8'd0);
  assign frame_ok  = !st.at_frame_start && dist_zero &&
                     (st.frame_bytes >= MIN_BYTES_BEFORE_DELIM);
  // a zero counter means this byte is the next code byte
  assign dist_base = dist_zero ? in_byte : st.distance_left;
  assign bytes_inc = (st.frame_bytes == BYTE_COUNT_MAX) ? st.frame_bytes
                                                        : st.frame_bytes + 16'd1;

  always_comb begin
    st_next = st;
    res     = '0;
    priority if (is_delim) begin
      st_next        = STATE_RESET;
      res.valid      = 1'b1;
      res.frame_end  = 1'b1;
      res.status     = !frame_ok;
      res.byte_count = st.frame_bytes;
    end else if (st.at_frame_start) begin
      st_next.at_frame_start = 1'b0;
      st_next.distance_left  = in_byte - 8'd1;
      st_next.frame_bytes    = 16'd1;
    end else begin
      st_next.distance_left = dist_base - 8'd1;
      st_next.frame_bytes   = bytes_inc;
      res.valid             = 1'b1;
      res.out_byte          = dist_zero ? delimiter_byte : in_byte;
      res.byte_count        = bytes_inc;
    end
  end

endmodule

[sv/cobs_frame_decoder.sv]
// COBS frame decoder: takes one encoded byte per cycle, while the output does
// not stall it, and gives back the decoded bytes, plus one end-of-frame result
// (status 0 ok, 1 error, and the count of encoded bytes before the delimiter)
// for every delimiter byte. A code byte at frame start gives no result.
// Throughput is one byte per clock while the output is not stalled, set by the
// combinational update of the distance counter and byte count. A taken byte
// goes into the input register and then, once the result register is free or
// being drained, is decoded into the result register, which offers its result.
// Write the delimiter only while the block is idle.
module cobs_frame_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        frame_end,
  output logic        status,
  output logic [15:0] byte_count
);
  import cfd_pkg::*;

  logic        [7:0] delimiter_byte;
  logic              hold_valid;
  logic        [7:0] hold_byte;
  logic              advance;
  cfd_state_t        st;
  cfd_state_t        st_next;
  cfd_result_t       res;

  // the held byte moves on when the result register is free or being drained
  assign advance  = hold_valid && (!out_valid || out_ready);
  assign in_ready = !hold_valid || advance;

  cfd_core u_core (
    .in_byte        (hold_byte),
    .delimiter_byte (delimiter_byte),
    .st             (st),
    .st_next        (st_next),
    .res            (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      delimiter_byte <= 8'd0;
    end else if (cfg_we) begin
      delimiter_byte <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_ready) begin
      hold_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold_byte <= in_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= STATE_RESET;
    end else if (advance) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= res.valid;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.valid) begin
      out_byte   <= res.out_byte;
      frame_end  <= res.frame_end;
      status     <= res.status;
      byte_count <= res.byte_count;
    end
  end

  a_ok_frame_len: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_end && !status |-> byte_count >= MIN_BYTES_BEFORE_DELIM)
    else $error("ok frame shorter than minimum");

  a_data_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && !frame_end |-> !status && byte_count >= 16'd2)
    else $error("data result with bad status or count");

  a_restart: assert property (@(posedge clk) disable iff (rst)
    advance && res.valid && res.frame_end |=>
      st.at_frame_start && st.frame_bytes == 16'd0 && out_valid)
    else $error("frame end did not restart the frame");

  a_in_frame_count: assert property (@(posedge clk) disable iff (rst)
    !st.at_frame_start |-> st.frame_bytes != 16'd0)
    else $error("open frame with zero byte count");

endmodule
